// ===== src/cnhb_pkg.sv =====
// Package for the CAN node heartbeat and status frame core.
// Holds the transaction payload types, frame constants and the byte XOR check.
// Used by can_node_heartbeat_pdo_core and cnhb_checker.
package cnhb_pkg;

   // Identifier bases, NMT command codes and lead bytes.
   localparam logic [10:0] ID_HEARTBEAT = 11'h700;
   localparam logic [10:0] ID_STATUS    = 11'h180;
   localparam logic [10:0] ID_COMMAND   = 11'h200;
   localparam logic [7:0]  NMT_START    = 8'h01;
   localparam logic [7:0]  NMT_STOP     = 8'h02;
   localparam logic [7:0]  CMD_LEAD     = 8'h01;
   localparam logic [7:0]  STATUS_LEAD  = 8'h01;

   // Item kinds.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   // Frame lengths.
   localparam logic [3:0] LEN_NMT       = 4'd2;
   localparam logic [3:0] LEN_FULL      = 4'd8;
   localparam logic [3:0] LEN_HEARTBEAT = 4'd1;

   // Configuration register indexes.
   localparam logic [1:0] REG_NODE_ID      = 2'd0;
   localparam logic [1:0] REG_HB_INTERVAL  = 2'd1;
   localparam logic [1:0] REG_DEF_INTERVAL = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [6:0]  NODE_ID_RESET      = 7'd1;
   localparam logic [15:0] HB_INTERVAL_RESET  = 16'd300;
   localparam logic [7:0]  DEF_INTERVAL_RESET = 8'd10;

   typedef struct packed {
      logic        kind;
      logic [10:0] rx_id;
      logic [3:0]  rx_len;
      logic [63:0] rx_payload;
      logic [7:0]  input_low_bits;
      logic [7:0]  input_high_bits;
      logic [7:0]  output_bits;
      logic [7:0]  control_status;
      logic [7:0]  error_code;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [3:0]  tx_len;
      logic [63:0] tx_payload;
      logic [7:0]  light_command;
      logic [7:0]  control_command;
      logic        operational;
   } rsp_type;

   // XOR of bytes 0 through 6 of a frame payload.
   function automatic logic [7:0] xor_low_seven(input logic [63:0] word);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 7; i++) begin
         acc = acc ^ word[8*i +: 8];
      end
      return acc;
   endfunction

endpackage

// ===== src/can_node_heartbeat_pdo_core.sv =====
// Top level of the CAN node heartbeat and status frame core.
// Depends on cnhb_pkg for payload types, constants and the XOR check.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   cnhb_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   cnhb_pkg::rsp_type
//   csr      in/out     APB psel/penable      three registers, 32-bit data
//
// The node state updates at acceptance and the result lands in the output register
// the cycle after.
// One transaction per cycle is sustained; req_ready drops only while a result
// waits in the output register and rsp_ready is low.
// Reset is synchronous and active high; it clears node state and restores the
// configuration registers to their defaults. No clearing pass is needed.
module can_node_heartbeat_pdo_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cnhb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cnhb_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import cnhb_pkg::*;

   // Configuration registers.
   logic [6:0]  node_id_ff;
   logic [15:0] hb_interval_ff;
   logic [7:0]  def_interval_ff;

   // Node state.
   logic        running_ff, running_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [7:0]  light_ff, light_in;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  period_ff, period_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   logic        accept;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] tick_next;
   logic [7:0]  period_eff;
   logic [10:0] command_id;
   logic [63:0] status_word;
   logic        nmt_mine;
   logic        command_ok;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   // Register reads.
   always_comb begin
      unique case (csr_index)
         REG_NODE_ID:      prdata = {25'd0, node_id_ff};
         REG_HB_INTERVAL:  prdata = {16'd0, hb_interval_ff};
         REG_DEF_INTERVAL: prdata = {24'd0, def_interval_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff      <= NODE_ID_RESET;
         hb_interval_ff  <= HB_INTERVAL_RESET;
         def_interval_ff <= DEF_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_NODE_ID:      node_id_ff      <= pwdata[6:0];
            REG_HB_INTERVAL:  hb_interval_ff  <= pwdata[15:0];
            REG_DEF_INTERVAL: def_interval_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // A transaction enters whenever the output register is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Shared frame decode terms.
   assign tick_next  = tick_count_ff + 16'd1;
   assign period_eff = (period_ff == 8'd0) ? def_interval_ff : period_ff;
   assign command_id = ID_COMMAND + {4'd0, node_id_ff};
   assign nmt_mine   = (req_payload.rx_payload[15:8] == 8'd0) ||
                       (req_payload.rx_payload[15:8] == {1'b0, node_id_ff});
   assign command_ok = (req_payload.rx_len == LEN_FULL) &&
                       (req_payload.rx_payload[7:0] == CMD_LEAD) &&
                       (xor_low_seven(req_payload.rx_payload) ==
                        req_payload.rx_payload[63:56]);

   // Status frame bytes 0 through 6, checksum in byte 7.
   always_comb begin
      status_word = {8'd0, req_payload.error_code, req_payload.control_status,
                     req_payload.output_bits, req_payload.input_high_bits,
                     req_payload.input_low_bits, light_ff, STATUS_LEAD};
      status_word[63:56] = xor_low_seven(status_word);
   end

   // Step of the node for one transaction.
   always_comb begin
      running_in     = running_ff;
      tick_count_in  = tick_count_ff;
      light_in       = light_ff;
      control_in     = control_ff;
      period_in      = period_ff;
      rsp_payload_in = '0;
      if (req_payload.kind == KIND_TICK) begin
         tick_count_in = tick_next;
         if (!running_ff) begin
            if (tick_next > hb_interval_ff) begin
               tick_count_in           = 16'd0;
               rsp_payload_in.tx_valid = 1'b1;
               rsp_payload_in.tx_id    = ID_HEARTBEAT + {4'd0, node_id_ff};
               rsp_payload_in.tx_len   = LEN_HEARTBEAT;
            end
         end else begin
            period_in = period_eff;
            if (tick_next > {8'd0, period_eff}) begin
               tick_count_in             = 16'd0;
               rsp_payload_in.tx_valid   = 1'b1;
               rsp_payload_in.tx_id      = ID_STATUS + {4'd0, node_id_ff};
               rsp_payload_in.tx_len     = LEN_FULL;
               rsp_payload_in.tx_payload = status_word;
            end
         end
      end else if (req_payload.rx_id == 11'd0) begin
         // Broadcast NMT start or stop.
         if (req_payload.rx_len == LEN_NMT && nmt_mine) begin
            if (req_payload.rx_payload[7:0] == NMT_START) begin
               running_in = 1'b1;
            end else if (req_payload.rx_payload[7:0] == NMT_STOP) begin
               running_in = 1'b0;
            end
         end
      end else if (req_payload.rx_id == command_id && command_ok) begin
         // Command frame: light only when nonzero, period may be zero.
         if (req_payload.rx_payload[15:8] != 8'd0) begin
            light_in = req_payload.rx_payload[15:8];
         end
         control_in = req_payload.rx_payload[23:16];
         period_in  = req_payload.rx_payload[31:24];
      end
      rsp_payload_in.light_command   = light_in;
      rsp_payload_in.control_command = control_in;
      rsp_payload_in.operational     = running_in;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // Node state and output control.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         tick_count_ff <= 16'd0;
         light_ff      <= 8'd0;
         control_ff    <= 8'd0;
         period_ff     <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            running_ff    <= running_in;
            tick_count_ff <= tick_count_in;
            light_ff      <= light_in;
            control_ff    <= control_in;
            period_ff     <= period_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/cnhb_checker.sv =====
// Port-level checks for the CAN node heartbeat and status frame core.
// Depends on cnhb_pkg; bound to can_node_heartbeat_pdo_core below.
module cnhb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cnhb_pkg::rsp_type rsp_payload
);
   import cnhb_pkg::*;

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Every accepted transaction yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // With no frame sent, the frame fields are all zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.tx_valid |->
         rsp_payload.tx_id == 11'd0 && rsp_payload.tx_len == 4'd0 &&
         rsp_payload.tx_payload == 64'd0)
      else $error("idle result carries frame data");

   // A sent frame is a one-byte zero heartbeat or a checked status frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tx_valid |->
         (rsp_payload.tx_len == LEN_HEARTBEAT && rsp_payload.tx_payload == 64'd0) ||
         (rsp_payload.tx_len == LEN_FULL &&
          rsp_payload.tx_payload[7:0] == STATUS_LEAD &&
          rsp_payload.tx_payload[63:56] == xor_low_seven(rsp_payload.tx_payload)))
      else $error("malformed transmitted frame");

endmodule

bind can_node_heartbeat_pdo_core cnhb_checker u_cnhb_checker (.*);
